// ===== sv/stepper_travel_and_stall_monitor_assert.svh =====
// ----------------------------------------------------------------------------
// stepper travel and stall monitor assertion macros
// shared property forms, sampled on clk and disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef STEPPER_TRAVEL_AND_STALL_MONITOR_ASSERT_SVH
`define STEPPER_TRAVEL_AND_STALL_MONITOR_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define STMON_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define STMON_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/stmon_pkg.sv =====
// ----------------------------------------------------------------------------
// stmon_pkg
// shared types and constants of the stepper travel and stall monitor
// ----------------------------------------------------------------------------
package stmon_pkg;

  localparam int DATA_W      = 10;
  localparam int TARGET_W    = 32;
  localparam int TRAVEL_W    = 33;
  localparam int PCT_W       = 7;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // percent scale of the learned threshold
  localparam int PCT_FULL    = 100;
  localparam int PCT_PROD_W  = DATA_W + PCT_W;

  localparam logic [PCT_W-1:0] PCT_RESET = PCT_W'(60);
  localparam logic [PCT_W-1:0] PCT_LIMIT = PCT_W'(PCT_FULL);

  typedef logic [DATA_W-1:0] data_t;

  typedef enum logic [1:0] {
    END_RUNNING,
    END_TARGET,
    END_STALL
  } end_reason_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TARGET_STEPS,
    CFG_FORWARD,
    CFG_TRAVEL_LIMIT_ENABLE,
    CFG_STALL_CHECK,
    CFG_USE_FIXED_THRESHOLD,
    CFG_FIXED_THRESHOLD,
    CFG_STALL_PERCENT
  } cfg_index_t;

  typedef struct packed {
    logic clear;
    logic take;
    logic fixed_mode;
  } win_ctl_t;

  typedef struct packed {
    logic  was_full;
    data_t average;
  } win_stat_t;

endpackage

// ===== sv/stmon_window.sv =====
// ----------------------------------------------------------------------------
// stmon_window
// load reading shift line with running sums over both window lengths and
// a constant-reciprocal divide that yields the window average
// ----------------------------------------------------------------------------
`include "stepper_travel_and_stall_monitor_assert.svh"

module stmon_window import stmon_pkg::*; #(
  parameter int LEARN_WINDOW = 10,
  parameter int FIXED_WINDOW = 5
) (
  input  logic      clk,
  input  logic      rst,
  input  win_ctl_t  ctl,
  input  data_t     load_value,
  output win_stat_t stat
);

  localparam int DEPTH   = (LEARN_WINDOW > FIXED_WINDOW) ? LEARN_WINDOW : FIXED_WINDOW;
  localparam int FILL_W  = $clog2(DEPTH + 1);
  localparam int SUM_W   = $clog2(((2 ** DATA_W) - 1) * DEPTH + 1);
  localparam int RECIP_K = SUM_W + $clog2(DEPTH);
  localparam int PROD_W  = SUM_W + RECIP_K;

  // ceil(2^K / w) gives an exact floor quotient for every SUM_W-bit sum
  localparam longint unsigned RECIP_LEARN =
    ((64'd1 << RECIP_K) + LEARN_WINDOW - 1) / LEARN_WINDOW;
  localparam longint unsigned RECIP_FIXED =
    ((64'd1 << RECIP_K) + FIXED_WINDOW - 1) / FIXED_WINDOW;

  localparam logic [RECIP_K-1:0] RECIP_LEARN_V = RECIP_K'(RECIP_LEARN);
  localparam logic [RECIP_K-1:0] RECIP_FIXED_V = RECIP_K'(RECIP_FIXED);
  localparam logic [FILL_W-1:0]  LEARN_LEN     = FILL_W'(LEARN_WINDOW);
  localparam logic [FILL_W-1:0]  FIXED_LEN     = FILL_W'(FIXED_WINDOW);
  localparam logic [FILL_W-1:0]  DEPTH_LEN     = FILL_W'(DEPTH);

  data_t              taps      [DEPTH];
  data_t              taps_next [DEPTH];
  logic [FILL_W-1:0]  fill, fill_next;
  logic [SUM_W-1:0]   sum_learn, sum_learn_next;
  logic [SUM_W-1:0]   sum_fixed, sum_fixed_next;
  logic [FILL_W-1:0]  win_len;
  logic [SUM_W-1:0]   sum_sel;
  logic [RECIP_K-1:0] recip_sel;
  logic [PROD_W-1:0]  prod;
  data_t              quot;

  always_comb begin
    win_len        = ctl.fixed_mode ? FIXED_LEN : LEARN_LEN;
    taps_next      = taps;
    fill_next      = fill;
    sum_learn_next = sum_learn;
    sum_fixed_next = sum_fixed;

    if (ctl.clear) begin
      for (int i = 0; i < DEPTH; i++) begin
        taps_next[i] = '0;
      end
      fill_next      = '0;
      sum_learn_next = '0;
      sum_fixed_next = '0;
    end else if (ctl.take) begin
      taps_next[0] = load_value;
      for (int i = 1; i < DEPTH; i++) begin
        taps_next[i] = taps[i-1];
      end
      if (fill != DEPTH_LEN) begin
        fill_next = fill + 1'b1;
      end
      // new reading enters, the oldest of each window drops out
      sum_learn_next = sum_learn + SUM_W'(load_value) - SUM_W'(taps[LEARN_WINDOW-1]);
      sum_fixed_next = sum_fixed + SUM_W'(load_value) - SUM_W'(taps[FIXED_WINDOW-1]);
    end

    sum_sel   = ctl.fixed_mode ? sum_fixed_next : sum_learn_next;
    recip_sel = ctl.fixed_mode ? RECIP_FIXED_V : RECIP_LEARN_V;
    prod      = PROD_W'(sum_sel) * PROD_W'(recip_sel);
    quot      = prod[RECIP_K +: DATA_W];

    stat.was_full = (fill >= win_len);
    stat.average  = (fill_next >= win_len) ? quot : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        taps[i] <= '0;
      end
      fill      <= '0;
      sum_learn <= '0;
      sum_fixed <= '0;
    end else begin
      taps      <= taps_next;
      fill      <= fill_next;
      sum_learn <= sum_learn_next;
      sum_fixed <= sum_fixed_next;
    end
  end

  `STMON_ASSERT_SAME(a_fill_bounded, 1'b1, fill <= DEPTH_LEN, "window fill beyond depth")
  `STMON_ASSERT_NEXT(a_clear_empties, ctl.clear, fill == '0 && sum_learn == '0 && sum_fixed == '0, "window not empty after clear")
  `STMON_ASSERT_NEXT(a_idle_holds, !ctl.clear && !ctl.take, $stable(fill) && $stable(sum_learn) && $stable(sum_fixed), "window changed without a reading")

endmodule

// ===== sv/stepper_travel_and_stall_monitor.sv =====
// ----------------------------------------------------------------------------
// stepper_travel_and_stall_monitor
// accumulates microstep travel from a wrapping counter and ends the move on
// target travel or on a load window average below a fixed or learned threshold
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_stall   start_req, step_count, load_value
//  out      source     out_valid / out_stall done_res, end_reason, travelled,
//                                            window_average
//  cfg      sink       cfg_wr_en             cfg_index, cfg_data
//
// one item per cycle sustained while the result side is not stalled; a taken
// item passes through the input register, then the result register
// travel, window and threshold state update in one pass between the two registers
// rst clears the session as if a start item had latched counter 0
// in_stall rises only while the input register is full and the result is held
// ----------------------------------------------------------------------------
`include "stepper_travel_and_stall_monitor_assert.svh"

module stepper_travel_and_stall_monitor import stmon_pkg::*; #(
  parameter int COUNTER_WRAP = 1024,
  parameter int LEARN_WINDOW = 10,
  parameter int FIXED_WINDOW = 5
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   start_req,
  input  logic [DATA_W-1:0]      step_count,
  input  logic [DATA_W-1:0]      load_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   done_res,
  output logic [1:0]             end_reason,
  output logic [TRAVEL_W-1:0]    travelled,
  output logic [DATA_W-1:0]      window_average
);

  localparam int CNT_W         = $clog2(COUNTER_WRAP);
  localparam int RED_W         = ((DATA_W > CNT_W) ? DATA_W : CNT_W) + 1;
  localparam int REDUCE_STEPS  = ((2 ** DATA_W) - 1) / COUNTER_WRAP;
  localparam logic [RED_W-1:0] WRAP_R = RED_W'(COUNTER_WRAP);
  localparam logic [CNT_W:0]   WRAP_D = (CNT_W + 1)'(COUNTER_WRAP);

  // configuration
  logic [TARGET_W-1:0] target_steps;
  logic                forward;
  logic                travel_limit_enable;
  logic                stall_check;
  logic                use_fixed_threshold;
  data_t               fixed_threshold;
  logic [PCT_W-1:0]    stall_percent;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_steps        <= '0;
      forward             <= 1'b1;
      travel_limit_enable <= 1'b1;
      stall_check         <= 1'b1;
      use_fixed_threshold <= 1'b0;
      fixed_threshold     <= '0;
      stall_percent       <= PCT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_TARGET_STEPS:        target_steps        <= cfg_data[TARGET_W-1:0];
        CFG_FORWARD:             forward             <= cfg_data[0];
        CFG_TRAVEL_LIMIT_ENABLE: travel_limit_enable <= cfg_data[0];
        CFG_STALL_CHECK:         stall_check         <= cfg_data[0];
        CFG_USE_FIXED_THRESHOLD: use_fixed_threshold <= cfg_data[0];
        CFG_FIXED_THRESHOLD:     fixed_threshold     <= cfg_data[DATA_W-1:0];
        CFG_STALL_PERCENT:       stall_percent       <= cfg_data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic             s1_valid;
  logic             s1_start;
  logic [CNT_W-1:0] s1_count;
  data_t            s1_load;
  logic [RED_W-1:0] cnt_red;
  logic             adv;

  // counter reading taken modulo the wrap
  always_comb begin
    cnt_red = RED_W'(step_count);
    for (int i = 0; i < REDUCE_STEPS; i++) begin
      if (cnt_red >= WRAP_R) begin
        cnt_red = cnt_red - WRAP_R;
      end
    end
  end

  assign adv      = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_start <= start_req;
      s1_count <= cnt_red[CNT_W-1:0];
      s1_load  <= load_value;
    end
  end

  // session state
  logic [CNT_W-1:0]    prev_count, prev_count_next;
  logic [TRAVEL_W-1:0] travel, travel_next;
  logic                finished, finished_next;
  end_reason_t         finish_reason, finish_reason_next;
  logic                baseline_learned, baseline_learned_next;
  data_t               base_avg, base_avg_next;
  logic [PCT_W-1:0]    base_pct, base_pct_next;

  win_ctl_t  win_ctl;
  win_stat_t win_stat;

  logic [CNT_W-1:0]      cnt_before, cnt_after;
  logic [CNT_W:0]        cnt_diff, delta;
  logic [TRAVEL_W:0]     travel_sum;
  logic [TRAVEL_W-1:0]   travel_add;
  logic                  reach;
  logic [PCT_W-1:0]      pct_sat;
  logic [PCT_PROD_W-1:0] stall_lhs, stall_rhs;
  logic                  stall_learned;

  stmon_window #(
    .LEARN_WINDOW (LEARN_WINDOW),
    .FIXED_WINDOW (FIXED_WINDOW)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .ctl        (win_ctl),
    .load_value (s1_load),
    .stat       (win_stat)
  );

  always_comb begin
    // roles swap when the counter falls
    cnt_before = forward ? prev_count : s1_count;
    cnt_after  = forward ? s1_count : prev_count;
    cnt_diff   = {1'b0, cnt_after} - {1'b0, cnt_before};
    if (cnt_after == cnt_before) begin
      delta = WRAP_D;
    end else if (cnt_after > cnt_before) begin
      delta = cnt_diff;
    end else begin
      delta = cnt_diff + WRAP_D;
    end

    travel_sum = {1'b0, travel} + (TRAVEL_W + 1)'(delta);
    travel_add = travel_sum[TRAVEL_W] ? '1 : travel_sum[TRAVEL_W-1:0];
    reach      = travel_limit_enable && (travel_add >= TRAVEL_W'(target_steps));

    pct_sat = (stall_percent > PCT_LIMIT) ? PCT_LIMIT : stall_percent;

    // avg < floor(base * pct / 100) is the same as 100 * (avg + 1) <= base * pct
    stall_lhs     = PCT_PROD_W'(win_stat.average) * PCT_PROD_W'(PCT_FULL)
                    + PCT_PROD_W'(PCT_FULL);
    stall_rhs     = PCT_PROD_W'(base_avg) * PCT_PROD_W'(base_pct);
    stall_learned = (stall_lhs <= stall_rhs);

    prev_count_next       = prev_count;
    travel_next           = travel;
    finished_next         = finished;
    finish_reason_next    = finish_reason;
    baseline_learned_next = baseline_learned;
    base_avg_next         = base_avg;
    base_pct_next         = base_pct;
    win_ctl.clear         = 1'b0;
    win_ctl.take          = 1'b0;
    win_ctl.fixed_mode    = use_fixed_threshold;

    if (adv) begin
      if (s1_start) begin
        prev_count_next       = s1_count;
        travel_next           = '0;
        finished_next         = 1'b0;
        finish_reason_next    = END_RUNNING;
        baseline_learned_next = 1'b0;
        win_ctl.clear         = 1'b1;
      end else if (!finished) begin
        travel_next     = travel_add;
        prev_count_next = s1_count;
        if (reach) begin
          finished_next      = 1'b1;
          finish_reason_next = END_TARGET;
        end else if (stall_check) begin
          win_ctl.take = 1'b1;
          if (win_stat.was_full) begin
            if (use_fixed_threshold) begin
              if (win_stat.average < fixed_threshold) begin
                finished_next      = 1'b1;
                finish_reason_next = END_STALL;
              end
            end else if (!baseline_learned) begin
              // first full window only sets the baseline
              baseline_learned_next = 1'b1;
              base_avg_next         = win_stat.average;
              base_pct_next         = pct_sat;
            end else if (stall_learned) begin
              finished_next      = 1'b1;
              finish_reason_next = END_STALL;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_count       <= '0;
      travel           <= '0;
      finished         <= 1'b0;
      finish_reason    <= END_RUNNING;
      baseline_learned <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      prev_count       <= prev_count_next;
      travel           <= travel_next;
      finished         <= finished_next;
      finish_reason    <= finish_reason_next;
      baseline_learned <= baseline_learned_next;
      if (adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    base_avg <= base_avg_next;
    base_pct <= base_pct_next;
    if (adv) begin
      done_res       <= finished_next;
      end_reason     <= finish_reason_next;
      travelled      <= travel_next;
      window_average <= win_stat.average;
    end
  end

  `STMON_ASSERT_SAME(a_reason_tracks_done, 1'b1, finished == (finish_reason != END_RUNNING), "end reason out of step with done")
  `STMON_ASSERT_NEXT(a_start_clears, adv && s1_start, travel == '0 && !finished && !baseline_learned, "start item left session state")
  `STMON_ASSERT_NEXT(a_ended_holds, adv && !s1_start && finished, $stable(travel) && $stable(finish_reason), "ended move changed")

endmodule

// ===== bench/stepper_travel_and_stall_monitor_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stepper travel and stall monitor testbench
// walks a directed table of tick samples and register writes, then random
// move sessions under random register settings, with random gaps on the input
// and random stalls on the result side; every result is compared field by field
// against its table row or an in-bench model of travel, load window, end of move
// ----------------------------------------------------------------------------
module stepper_travel_and_stall_monitor_tb;
  import stmon_pkg::*;

  localparam int COUNT_WRAP   = 1024;
  localparam int LEARN_LEN    = 10;
  localparam int FIXED_LEN    = 5;
  localparam int WINDOW_DEPTH = 10;
  localparam longint TRAVEL_TOP = 64'h1_FFFF_FFFF;
  localparam int RANDOM_ITEMS = 1300;
  localparam int STUCK_LIMIT  = 2000;
  localparam int MAX_REPORTS  = 40;

  typedef struct {
    logic                done;
    end_reason_t         why;
    logic [TRAVEL_W-1:0] span;
    data_t               avg;
  } move_status_t;

  typedef enum bit {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    cfg_index_t            reg_id;
    logic [CFG_DATA_W-1:0] value;
    logic                  start;
    data_t                 count;
    data_t                 load;
    bit                    typed;
    move_status_t          want;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   start_req = 1'b0;
  data_t                  step_count = '0;
  data_t                  load_value = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   done_res;
  logic [1:0]             end_reason;
  logic [TRAVEL_W-1:0]    travelled;
  data_t                  window_average;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stepper_travel_and_stall_monitor i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .start_req      (start_req),
    .step_count     (step_count),
    .load_value     (load_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .done_res       (done_res),
    .end_reason     (end_reason),
    .travelled      (travelled),
    .window_average (window_average)
  );

  // register copies
  logic [TARGET_W-1:0] target_reg  = '0;
  logic                forward_reg = 1'b1;
  logic                limit_reg   = 1'b1;
  logic                stall_reg   = 1'b1;
  logic                fixed_reg   = 1'b0;
  data_t               thresh_reg  = '0;
  logic [PCT_W-1:0]    pct_reg     = PCT_RESET;

  // move session
  data_t       prior_count = '0;
  longint      travel_sum  = 0;
  data_t       loads [WINDOW_DEPTH] = '{default: '0};
  int          fill = 0;
  bit          baseline_set = 1'b0;
  data_t       stall_level = '0;
  bit          move_ended = 1'b0;
  end_reason_t ended_by = END_RUNNING;

  move_status_t status_q [$];
  int errors = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  function automatic int window_len();
    return fixed_reg ? FIXED_LEN : LEARN_LEN;
  endfunction

  function automatic data_t load_average();
    int len;
    int sum;
    int i;
    len = window_len();
    sum = 0;
    if (fill < len) return '0;
    for (i = 0; i < len; i++) sum += int'(loads[i]);
    return data_t'(sum / len);
  endfunction

  // backward motion swaps the readings; an unchanged counter is a full wrap
  function automatic int count_advance(data_t was, data_t now);
    int lo;
    int hi;
    lo = forward_reg ? int'(was) : int'(now);
    hi = forward_reg ? int'(now) : int'(was);
    if (hi == lo) return COUNT_WRAP;
    if (hi > lo) return hi - lo;
    return COUNT_WRAP - lo + hi;
  endfunction

  function automatic void absorb_load(data_t l);
    int    len;
    bit    was_full;
    data_t avg;
    int    pct;
    int    i;
    len = window_len();
    was_full = fill >= len;
    for (i = WINDOW_DEPTH - 1; i > 0; i--) loads[i] = loads[i-1];
    loads[0] = l;
    if (fill < WINDOW_DEPTH) fill++;
    if (!was_full) return;
    avg = load_average();
    if (fixed_reg) begin
      if (avg < thresh_reg) begin
        move_ended = 1'b1;
        ended_by = END_STALL;
      end
    end else if (!baseline_set) begin
      // first full window only learns the threshold
      pct = (pct_reg > PCT_LIMIT) ? PCT_FULL : int'(pct_reg);
      stall_level = data_t'(int'(avg) * pct / PCT_FULL);
      baseline_set = 1'b1;
    end else if (avg < stall_level) begin
      move_ended = 1'b1;
      ended_by = END_STALL;
    end
  endfunction

  function automatic move_status_t advance_move(logic s, data_t c, data_t l);
    move_status_t r;
    if (s) begin
      prior_count = c;
      travel_sum = 0;
      loads = '{default: '0};
      fill = 0;
      baseline_set = 1'b0;
      stall_level = '0;
      move_ended = 1'b0;
      ended_by = END_RUNNING;
    end else if (!move_ended) begin
      travel_sum += longint'(count_advance(prior_count, c));
      if (travel_sum > TRAVEL_TOP) travel_sum = TRAVEL_TOP;
      prior_count = c;
      // reaching the target skips the load reading of that item
      if (limit_reg && travel_sum >= longint'(target_reg)) begin
        move_ended = 1'b1;
        ended_by = END_TARGET;
      end else if (stall_reg) begin
        absorb_load(l);
      end
    end
    r.done = move_ended;
    r.why = ended_by;
    r.span = travel_sum[TRAVEL_W-1:0];
    r.avg = load_average();
    return r;
  endfunction

  function automatic plan_row_t item_row(logic s, int c, int l);
    plan_row_t r;
    r.kind = ROW_ITEM;
    r.reg_id = CFG_TARGET_STEPS;
    r.value = '0;
    r.start = s;
    r.count = data_t'(c);
    r.load = data_t'(l);
    r.typed = 1'b0;
    r.want = '{1'b0, END_RUNNING, '0, '0};
    return r;
  endfunction

  function automatic plan_row_t typed_row(logic s, int c, int l, logic d, end_reason_t w,
                                          longint t, int a);
    plan_row_t r;
    r = item_row(s, c, l);
    r.typed = 1'b1;
    r.want.done = d;
    r.want.why = w;
    r.want.span = TRAVEL_W'(t);
    r.want.avg = data_t'(a);
    return r;
  endfunction

  function automatic plan_row_t write_row(cfg_index_t idx, logic [CFG_DATA_W-1:0] v);
    plan_row_t r;
    r = item_row(1'b0, 0, 0);
    r.kind = ROW_WRITE;
    r.reg_id = idx;
    r.value = v;
    return r;
  endfunction

  task automatic flag_mismatch(string what);
    if (errors < MAX_REPORTS) $display("%0t mismatch: %s", $time, what);
    errors++;
  endtask

  task automatic check_status();
    move_status_t want;
    if (status_q.size() == 0) begin
      flag_mismatch("result with no item pending");
      return;
    end
    want = status_q[0];
    status_q.delete(0);
    if (done_res !== want.done)
      flag_mismatch($sformatf("done_res %0b, expected %0b", done_res, want.done));
    if (end_reason !== want.why)
      flag_mismatch($sformatf("end_reason %0d, expected %s", end_reason, want.why.name()));
    if (travelled !== want.span)
      flag_mismatch($sformatf("travelled %0d, expected %0d", travelled, want.span));
    if (window_average !== want.avg)
      flag_mismatch($sformatf("window_average %0d, expected %0d", window_average, want.avg));
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_TARGET_STEPS:        target_reg = val;
      CFG_FORWARD:             forward_reg = val[0];
      CFG_TRAVEL_LIMIT_ENABLE: limit_reg = val[0];
      CFG_STALL_CHECK:         stall_reg = val[0];
      CFG_USE_FIXED_THRESHOLD: fixed_reg = val[0];
      CFG_FIXED_THRESHOLD:     thresh_reg = val[DATA_W-1:0];
      CFG_STALL_PERCENT:       pct_reg = val[PCT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic feed_sample(logic s, data_t c, data_t l, output move_status_t pred);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid <= 1'b1;
    start_req <= s;
    step_count <= c;
    load_value <= l;
    do @(posedge clk); while (in_stall);
    pred = advance_move(s, c, l);
  endtask

  // wait until every pending result has come back
  task automatic settle_block();
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) check_status();
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STUCK_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    plan_row_t             plan [$];
    move_status_t          pred;
    bit                    writing;
    int                    sent;
    int                    phase_len;
    int                    roll;
    int                    step;
    int                    dip_left;
    int                    base;
    int                    pick;
    int                    k;
    logic                  s;
    data_t                 c;
    data_t                 l;
    data_t                 head;
    logic [CFG_DATA_W-1:0] tgt;
    logic [CFG_DATA_W-1:0] thr;
    logic [CFG_DATA_W-1:0] pct;

    // before any start, zero target: ends at once, then ignores items
    plan.insert(plan.size(), typed_row(1'b0, 5, 0, 1'b1, END_TARGET, 5, 0));
    plan.insert(plan.size(), typed_row(1'b0, 1023, 1023, 1'b1, END_TARGET, 5, 0));
    plan.insert(plan.size(), typed_row(1'b1, 1023, 0, 1'b0, END_RUNNING, 0, 0));
    plan.insert(plan.size(), typed_row(1'b0, 1023, 0, 1'b1, END_TARGET, 1024, 0));
    // learning mode, percent above hundred saturates
    plan.insert(plan.size(), write_row(CFG_TARGET_STEPS, 32'hFFFF_FFFF));
    plan.insert(plan.size(), write_row(CFG_STALL_PERCENT, 127));
    plan.insert(plan.size(), typed_row(1'b1, 0, 0, 1'b0, END_RUNNING, 0, 0));
    for (k = 1; k < 10; k++) plan.insert(plan.size(), item_row(1'b0, k, 1023));
    plan.insert(plan.size(), typed_row(1'b0, 10, 1023, 1'b0, END_RUNNING, 10, 1023));
    plan.insert(plan.size(), typed_row(1'b0, 11, 1023, 1'b0, END_RUNNING, 11, 1023));
    plan.insert(plan.size(), typed_row(1'b0, 12, 0, 1'b1, END_STALL, 12, 920));
    // backward counting, fixed threshold at its top
    plan.insert(plan.size(), write_row(CFG_FORWARD, 0));
    plan.insert(plan.size(), write_row(CFG_USE_FIXED_THRESHOLD, 1));
    plan.insert(plan.size(), write_row(CFG_FIXED_THRESHOLD, 1023));
    plan.insert(plan.size(), write_row(CFG_TARGET_STEPS, 3000));
    plan.insert(plan.size(), typed_row(1'b1, 0, 0, 1'b0, END_RUNNING, 0, 0));
    for (k = 1023; k > 1017; k--) plan.insert(plan.size(), item_row(1'b0, k, 1023));
    plan.insert(plan.size(), typed_row(1'b0, 1017, 1022, 1'b1, END_STALL, 7, 1022));
    // both limits off: move never ends
    plan.insert(plan.size(), write_row(CFG_TRAVEL_LIMIT_ENABLE, 0));
    plan.insert(plan.size(), write_row(CFG_STALL_CHECK, 0));
    plan.insert(plan.size(), write_row(CFG_FIXED_THRESHOLD, 0));
    plan.insert(plan.size(), write_row(CFG_TARGET_STEPS, 0));
    plan.insert(plan.size(), typed_row(1'b1, 512, 512, 1'b0, END_RUNNING, 0, 0));
    plan.insert(plan.size(), typed_row(1'b0, 512, 0, 1'b0, END_RUNNING, 1024, 0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    gap_pct = 24;
    stall_pct = 87;

    writing = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        if (!writing) settle_block();
        writing = 1'b1;
        write_reg(plan[i].reg_id, plan[i].value);
      end else begin
        if (writing) cfg_wr_en <= 1'b0;
        writing = 1'b0;
        feed_sample(plan[i].start, plan[i].count, plan[i].load, pred);
        status_q.insert(status_q.size(), plan[i].typed ? plan[i].want : pred);
      end
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent < RANDOM_ITEMS / 3) begin
        gap_pct = 24;
        stall_pct = 87;
      end else if (sent < 2 * RANDOM_ITEMS / 3) begin
        gap_pct = 87;
        stall_pct = 24;
      end else begin
        gap_pct = 0;
        stall_pct = 0;
      end

      base = $urandom_range(250, 950);
      pick = $urandom_range(9);
      if (pick == 0) tgt = '0;
      else if (pick == 1) tgt = 32'hFFFF_FFFF;
      else if (pick < 6) tgt = $urandom_range(1, 400);
      else tgt = $urandom_range(400, 30000);
      pick = $urandom_range(9);
      if (pick == 0) thr = 0;
      else if (pick == 1) thr = 1023;
      else thr = base * $urandom_range(40, 90) / 100;
      pick = $urandom_range(9);
      if (pick == 0) pct = 0;
      else if (pick == 1) pct = 100;
      else if (pick == 2) pct = 127;
      else pct = $urandom_range(50, 95);

      settle_block();
      write_reg(CFG_TARGET_STEPS, tgt);
      write_reg(CFG_FORWARD, $urandom_range(1));
      write_reg(CFG_TRAVEL_LIMIT_ENABLE, CFG_DATA_W'($urandom_range(3) != 0));
      write_reg(CFG_STALL_CHECK, CFG_DATA_W'($urandom_range(3) != 0));
      write_reg(CFG_USE_FIXED_THRESHOLD, $urandom_range(1));
      write_reg(CFG_FIXED_THRESHOLD, thr);
      write_reg(CFG_STALL_PERCENT, pct);
      cfg_wr_en <= 1'b0;

      // now and then the session carries on across the register change
      head = prior_count;
      if ($urandom_range(99) < 85) begin
        head = data_t'($urandom_range(0, 1023));
        feed_sample(1'b1, head, data_t'($urandom), pred);
        status_q.insert(status_q.size(), pred);
        sent++;
      end

      dip_left = 0;
      phase_len = $urandom_range(20, 80);
      repeat (phase_len) begin
        roll = $urandom_range(99);
        if (roll < 3) begin
          s = 1'b1;
          c = data_t'($urandom);
          l = data_t'($urandom);
        end else if (roll < 10) begin
          s = 1'b0;
          c = data_t'($urandom);
          l = data_t'($urandom);
        end else begin
          s = 1'b0;
          if (roll < 13) step = 0;
          else if (roll < 16) step = $urandom_range(1, 1023);
          else step = $urandom_range(1, 12);
          c = forward_reg ? data_t'(int'(head) + step) : data_t'(int'(head) - step);
          if (dip_left == 0 && $urandom_range(99) < 4) dip_left = $urandom_range(3, 12);
          // a load dip is what a stall looks like
          if (dip_left > 0) begin
            l = data_t'($urandom_range(0, base / 3));
            dip_left--;
          end else begin
            l = data_t'(base + $urandom_range(0, 80) - 40);
          end
        end
        feed_sample(s, c, l, pred);
        status_q.insert(status_q.size(), pred);
        head = c;
        sent++;
      end
    end

    settle_block();
    repeat (4) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== stepper_travel_and_stall_monitor.f =====
+incdir+sv
sv/stmon_pkg.sv
sv/stmon_window.sv
sv/stepper_travel_and_stall_monitor.sv
bench/stepper_travel_and_stall_monitor_tb.sv
